FILE: design/ols_pkg.sv
package ols_pkg;

	// Operation codes carried in the input tuser
	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_ERASE  = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_RESIZE = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Stream payload widths
	localparam int OP_W        = 3;
	localparam int POS_W       = 6;
	localparam int VAL_W       = 32;
	localparam int REQ_W       = 7;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 7;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// Controller to datapath
	typedef struct packed {
		logic       load;        // capture the accepted request
		logic       status_we;   // record the result status
		logic [1:0] status;
		logic       cnt_clr;
		logic       cnt_set;     // count takes the requested size
		logic       cnt_inc;
		logic       cnt_dec;
		logic       push_wr;     // write the value at the count
		logic       ptr_init_up; // pointer to the count
		logic       ptr_init_dn; // pointer to the position
		logic       step_up;     // read pointer-1, later write it at pointer
		logic       step_dn;     // read pointer+1, later write it at pointer
		logic       place_wr;    // write the value at the position
		logic       rd_pos;      // read the entry at the position
		logic       out_load;    // load the result register
	} ols_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       range_bad;
		logic       full;
		logic       resize_bad;
		logic       ptr_above_pos;
		logic       ptr_below_last;
		logic       out_free;
	} ols_stat_t;

endpackage

FILE: design/ordered_list_store.sv
// Channel   Dir  Signals                        Contents
// s_axis    in   tvalid tready tdata[47:0] tuser[2:0]  one operation request
// m_axis    out  tvalid tready tdata[47:0]     one result per request
//
// Sequence: push, clear, resize, read and unused codes pass decide and finish;
// erase also shifts the later entries down, insert shifts them up and then places.
// The entry memory does one read and one write per cycle, so an insert or erase
// moves one entry per cycle.
// Reset clears the fill count, the controller and the result valid; the entries
// are not cleared.
// A result waiting on m_axis does not block the next request; only its own
// result load waits for the output register to free.
module ordered_list_store import ols_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [5:0] position, [37:6] entry_value, [44:38] new_count, [47:45] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [2:0] op
	input  logic [OP_W-1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] status, [8:2] count, [40:9] read_data, [47:41] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	ols_cmd_t  cmd;
	ols_stat_t stat;

	// Sequence each request: decide, shift entries, place, then hand off the result
	ols_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the entries, the fill count and the result register
	ols_dpath #(
		.CAPACITY    (CAPACITY),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_tdata (s_axis_tdata),
		.in_tuser (s_axis_tuser),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

endmodule

FILE: design/ols_ctrl.sv
module ols_ctrl import ols_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ols_stat_t stat,
	output ols_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECIDE   = 3'd1;
	localparam logic [2:0] S_SHIFT_UP = 3'd2;
	localparam logic [2:0] S_PLACE    = 3'd3;
	localparam logic [2:0] S_SHIFT_DN = 3'd4;
	localparam logic [2:0] S_FINISH   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.status_we = 1'b1;
				cmd.status    = ST_OK;
				state_d       = S_FINISH;
				case (stat.op)
					OP_PUSH: begin
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.push_wr = 1'b1;
							cmd.cnt_inc = 1'b1;
						end
					end
					OP_INSERT: begin
						if (stat.range_bad) begin
							cmd.status = ST_RANGE;
						end else if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.ptr_init_up = 1'b1;
							state_d         = S_SHIFT_UP;
						end
					end
					OP_ERASE: begin
						if (stat.range_bad) begin
							cmd.status = ST_RANGE;
						end else begin
							cmd.ptr_init_dn = 1'b1;
							state_d         = S_SHIFT_DN;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					OP_RESIZE: begin
						if (stat.resize_bad) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.cnt_set = 1'b1;
						end
					end
					OP_READ: begin
						if (stat.range_bad) begin
							cmd.status = ST_RANGE;
						end else begin
							cmd.rd_pos = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_SHIFT_UP: begin
				if (stat.ptr_above_pos) begin
					cmd.step_up = 1'b1;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				state_d      = S_FINISH;
			end
			S_SHIFT_DN: begin
				if (stat.ptr_below_last) begin
					cmd.step_dn = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/ols_dpath.sv
module ols_dpath import ols_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ols_cmd_t               cmd,
	output ols_stat_t              stat,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic [OP_W-1:0]        in_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > REQ_W) ? CW : REQ_W;
	localparam int PAD_W = OUT_TDATA_W - VAL_W - COUNT_W - STATUS_W;

	logic [OP_W-1:0]        op_q;
	logic [POS_W-1:0]       pos_q;
	logic [VAL_W-1:0]       val_q;
	logic [REQ_W-1:0]       req_q;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          ptr_q;
	logic                   wr_pend_q;
	logic [AW-1:0]          wr_addr_q;
	logic [ENTRY_WIDTH-1:0] rdata_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	logic [ENTRY_WIDTH-1:0] mem [CAPACITY];

	logic [XW-1:0]          count_x;
	logic [XW-1:0]          pos_x;
	logic [XW-1:0]          ptr_x;
	logic [XW-1:0]          req_x;
	logic [XW-1:0]          cap_x;
	logic [AW-1:0]          pos_a;
	logic [AW-1:0]          raddr;
	logic                   rd_en;
	logic                   wr_en;
	logic [AW-1:0]          waddr;
	logic [ENTRY_WIDTH-1:0] wdata;
	logic [VAL_W-1:0]       rd_word;

	assign count_x = XW'(count_q);
	assign pos_x   = XW'(pos_q);
	assign ptr_x   = XW'(ptr_q);
	assign req_x   = XW'(req_q);
	assign cap_x   = XW'(CAPACITY);
	assign pos_a   = AW'(pos_q);

	assign stat.op             = op_q;
	assign stat.range_bad      = (pos_x >= count_x);
	assign stat.full           = (count_x >= cap_x);
	assign stat.resize_bad     = (req_x > cap_x);
	assign stat.ptr_above_pos  = (ptr_x > pos_x);
	assign stat.ptr_below_last = ((ptr_x + XW'(1)) < count_x);
	assign stat.out_free       = !m_valid_q || m_tready;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_tuser;
			pos_q <= in_tdata[POS_W-1:0];
			val_q <= in_tdata[POS_W+VAL_W-1:POS_W];
			req_q <= in_tdata[POS_W+VAL_W+REQ_W-1:POS_W+VAL_W];
		end
		if (cmd.status_we) begin
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_clr) begin
			count_q <= '0;
		end else if (cmd.cnt_set) begin
			count_q <= CW'(req_q);
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// shift pointer and the write that trails each read, issued in the cycle after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= cmd.step_up || cmd.step_dn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_init_up) begin
			ptr_q <= AW'(count_q);
		end else if (cmd.ptr_init_dn) begin
			ptr_q <= pos_a;
		end else if (cmd.step_up) begin
			ptr_q <= ptr_q - AW'(1);
		end else if (cmd.step_dn) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (cmd.step_up || cmd.step_dn) begin
			wr_addr_q <= ptr_q;
		end
	end

	always_comb begin
		rd_en = cmd.step_up || cmd.step_dn || cmd.rd_pos;
		if (cmd.step_up) begin
			raddr = ptr_q - AW'(1);
		end else if (cmd.step_dn) begin
			raddr = ptr_q + AW'(1);
		end else begin
			raddr = pos_a;
		end
	end

	always_comb begin
		wr_en = wr_pend_q || cmd.push_wr || cmd.place_wr;
		if (wr_pend_q) begin
			waddr = wr_addr_q;
			wdata = rdata_q;
		end else if (cmd.push_wr) begin
			waddr = AW'(count_q);
			wdata = ENTRY_WIDTH'(val_q);
		end else begin
			waddr = pos_a;
			wdata = ENTRY_WIDTH'(val_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// result register
	assign rd_word = ((op_q == OP_READ) && (status_q == ST_OK)) ? VAL_W'(rdata_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= {{PAD_W{1'b0}}, rd_word, count_x[COUNT_W-1:0], status_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_x <= cap_x)
		else $error("fill count above capacity");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q |-> !(cmd.push_wr || cmd.place_wr))
		else $error("trailing shift write collides with a value write");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over an untaken result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import ols_pkg::*;

	localparam int SLOTS = 64;
	localparam int RANDOM_REQUESTS = 2000;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  count;
		logic [31:0] read_data;
	} list_result_t;

	// Mirror of the store: applies each accepted request and keeps its result
	class list_scoreboard;
		logic [31:0]  slot_value [SLOTS];
		bit           slot_written [SLOTS];
		int           fill_level;
		int           errors;
		list_result_t expected [$];

		function new();
			fill_level = 0;
			errors = 0;
			foreach (slot_written[i])
				slot_written[i] = 1'b0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_request(logic [2:0] op, logic [5:0] pos, logic [31:0] val,
				logic [6:0] req);
			list_result_t res;
			int p;
			p = int'(pos);
			res.status = ST_OK;
			res.read_data = '0;
			case (op)
				OP_PUSH: begin
					if (fill_level >= SLOTS) begin
						res.status = ST_FULL;
					end else begin
						slot_value[fill_level] = val;
						slot_written[fill_level] = 1'b1;
						fill_level++;
					end
				end
				OP_INSERT: begin
					// position is checked before capacity
					if (p >= fill_level) begin
						res.status = ST_RANGE;
					end else if (fill_level >= SLOTS) begin
						res.status = ST_FULL;
					end else begin
						for (int i = fill_level; i > p; i--) begin
							slot_value[i] = slot_value[i-1];
							slot_written[i] = slot_written[i-1];
						end
						slot_value[p] = val;
						slot_written[p] = 1'b1;
						fill_level++;
					end
				end
				OP_ERASE: begin
					if (p >= fill_level) begin
						res.status = ST_RANGE;
					end else begin
						// the old last slot keeps its stale word
						for (int i = p; i + 1 < fill_level; i++) begin
							slot_value[i] = slot_value[i+1];
							slot_written[i] = slot_written[i+1];
						end
						fill_level--;
					end
				end
				OP_CLEAR: fill_level = 0;
				OP_RESIZE: begin
					if (req > SLOTS)
						res.status = ST_FULL;
					else
						fill_level = int'(req);
				end
				OP_READ: begin
					if (p >= fill_level)
						res.status = ST_RANGE;
					else
						res.read_data = slot_value[p];
				end
				default: ;
			endcase
			res.count = fill_level[6:0];
			expected.push_back(res);
		endfunction

		function void check_result(logic [47:0] beat);
			list_result_t want;
			if (expected.size() == 0) begin
				$display("%0t unexpected result %h", $time, beat);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (beat[1:0] !== want.status) begin
				$display("%0t status mismatch: expected %0d actual %0d",
					$time, want.status, beat[1:0]);
				errors++;
			end
			if (beat[8:2] !== want.count) begin
				$display("%0t count mismatch: expected %0d actual %0d",
					$time, want.count, beat[8:2]);
				errors++;
			end
			if (beat[40:9] !== want.read_data) begin
				$display("%0t read_data mismatch: expected %h actual %h",
					$time, want.read_data, beat[40:9]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [5:0] position, [37:6] entry_value, [44:38] new_count, [47:45] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// [2:0] op
	logic [OP_W-1:0]        s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [1:0] status, [8:2] count, [40:9] read_data, [47:41] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	list_scoreboard sb = new();

	int rx_mode = 0;
	int rx_left = 0;
	bit grow_phase = 1'b1;
	int phase_left = 0;

	ordered_list_store dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: switch between always ready, coin flip, rare ready and toggling
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= ~m_axis_tready;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Present one request at the falling edge and hold it until accepted
	task automatic send_request(input logic [2:0] op, input logic [5:0] pos,
			input logic [31:0] val, input logic [6:0] req);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b000, req, val, pos};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(op, pos, val, req);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Pick a request that mostly hits valid positions; grow and shrink phases
	// keep the count sweeping between empty and full.
	task automatic pick_request(output logic [2:0] op, output logic [5:0] pos,
			output logic [31:0] val, output logic [6:0] req);
		int fill;
		int r;
		int w_push, w_ins, w_era, w_read, w_rsz, w_clr;
		int start;
		int idx;
		bit found;
		fill = sb.fill_level;
		if (phase_left == 0) begin
			grow_phase = ~grow_phase;
			phase_left = $urandom_range(60, 200);
		end
		phase_left--;
		if (grow_phase) begin
			w_push = 34; w_ins = 26; w_era = 12; w_read = 20; w_rsz = 6; w_clr = 0;
		end else begin
			w_push = 12; w_ins = 12; w_era = 36; w_read = 26; w_rsz = 8; w_clr = 4;
		end
		r = $urandom_range(0, 99);
		if (r < w_push)
			op = OP_PUSH;
		else if (r < w_push + w_ins)
			op = OP_INSERT;
		else if (r < w_push + w_ins + w_era)
			op = OP_ERASE;
		else if (r < w_push + w_ins + w_era + w_read)
			op = OP_READ;
		else if (r < w_push + w_ins + w_era + w_read + w_rsz)
			op = OP_RESIZE;
		else if (r < w_push + w_ins + w_era + w_read + w_rsz + w_clr)
			op = OP_CLEAR;
		else
			op = 3'($urandom_range(6, 7));

		if (fill > 0 && $urandom_range(0, 9) != 0) begin
			case ($urandom_range(0, 7))
				0: pos = '0;
				1: pos = 6'(fill - 1);
				default: pos = 6'($urandom_range(0, fill - 1));
			endcase
		end else begin
			pos = 6'($urandom_range(0, 63));
		end

		if ($urandom_range(0, 15) == 0)
			val = {32{$urandom_range(0, 1) == 1}};
		else
			val = $urandom;

		case ($urandom_range(0, 9))
			6: req = 7'd64;
			7: req = 7'd0;
			8, 9: req = 7'($urandom_range(65, 127));
			default: req = 7'($urandom_range(0, 64));
		endcase

		// Never read a slot that nothing has written since reset
		if (op == OP_READ && pos < fill && !sb.slot_written[pos]) begin
			found = 1'b0;
			start = $urandom_range(0, fill - 1);
			for (int k = 0; k < fill && !found; k++) begin
				idx = (start + k) % fill;
				if (sb.slot_written[idx]) begin
					found = 1'b1;
					pos = 6'(idx);
				end
			end
			if (!found) begin
				if (fill < SLOTS)
					pos = 6'($urandom_range(fill, 63));
				else
					op = OP_PUSH;
			end
		end
	endtask

	initial begin
		logic [2:0]  op;
		logic [5:0]  pos;
		logic [31:0] val;
		logic [6:0]  req;
		int sent;
		int burst;

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty store, edges of the range, full store, oversize resize
		send_request(OP_READ,   6'd0,  32'h0,        7'd0);
		send_request(OP_ERASE,  6'd0,  32'h0,        7'd0);
		send_request(OP_INSERT, 6'd0,  32'hDEADBEEF, 7'd0);
		send_request(OP_PUSH,   6'd0,  32'h00000000, 7'd0);
		send_request(OP_PUSH,   6'd63, 32'hFFFFFFFF, 7'd127);
		send_request(OP_READ,   6'd1,  32'h0,        7'd0);
		send_request(OP_INSERT, 6'd0,  32'hA5A5A5A5, 7'd0);
		send_request(OP_INSERT, 6'd2,  32'h5A5A5A5A, 7'd0);
		send_request(OP_READ,   6'd63, 32'h0,        7'd0);
		send_request(OP_ERASE,  6'd3,  32'h0,        7'd0);
		send_request(OP_ERASE,  6'd0,  32'h0,        7'd0);
		send_request(OP_READ,   6'd0,  32'h0,        7'd0);
		send_request(OP_RESIZE, 6'd0,  32'h0,        7'd64);
		send_request(OP_PUSH,   6'd0,  32'h11111111, 7'd0);
		send_request(OP_INSERT, 6'd63, 32'h22222222, 7'd0);
		send_request(OP_INSERT, 6'd0,  32'h33333333, 7'd0);
		send_request(OP_RESIZE, 6'd0,  32'h0,        7'd65);
		send_request(OP_RESIZE, 6'd0,  32'h0,        7'd127);
		send_request(OP_ERASE,  6'd63, 32'h0,        7'd0);
		send_request(OP_INSERT, 6'd0,  32'h44444444, 7'd0);
		send_request(3'd6,      6'd5,  32'h0,        7'd3);
		send_request(3'd7,      6'd63, 32'hFFFFFFFF, 7'd127);
		send_request(OP_RESIZE, 6'd0,  32'h0,        7'd0);
		send_request(OP_PUSH,   6'd0,  32'h12345678, 7'd0);
		send_request(OP_CLEAR,  6'd0,  32'h0,        7'd0);

		// Random bursts; ignored codes do not advance the request total
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst; k++) begin
				pick_request(op, pos, val, req);
				send_request(op, pos, val, req);
				if (op <= OP_READ)
					sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 10));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// Drain, then give a late or extra result time to show up
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/ols_pkg.sv
design/ols_ctrl.sv
design/ols_dpath.sv
design/ordered_list_store.sv
bench/tb.sv
